FILE: design/camera_facing_backdrop_quad_top_defines.svh
// Assertion macros for the backdrop quad RTL, used by cfbq_emit.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef CAMERA_FACING_BACKDROP_QUAD_TOP_DEFINES_SVH
`define CAMERA_FACING_BACKDROP_QUAD_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFBQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("backdrop quad assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFBQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("backdrop quad assertion failed");

`endif

FILE: design/cfbq_pkg.sv
// Shared types, constants and sine polynomial steps for the backdrop quad block.
// No dependencies; every other file but the assertion macro header imports this package.
`timescale 1ns / 1ps
`default_nettype none
package cfbq_pkg;
    localparam logic [30:0] SIN_A1 = 31'd1686629713;
    localparam logic [29:0] SIN_A3 = 30'd688904837;
    localparam logic [26:0] SIN_A5 = 27'd76016948;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    localparam logic [2:0] CFG_SKY_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_RENDER_MODE   = 3'd1;
    localparam logic [2:0] CFG_FOV_Q8        = 3'd2;
    localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd4;
    localparam logic [1:0] MODE_MESH_ONLY    = 2'd1;

    typedef logic signed [17:0] q16_t;
    typedef logic signed [31:0] fix_t;
    typedef logic [2:0][3:0][31:0] quad_t;

    typedef struct packed {
        logic busy;
        logic allow;
        fix_t half_h;
        fix_t half_w;
    } setup_t;

    typedef struct packed {
        logic [30:0] orbit_d;
        fix_t        tx;
        fix_t        ty;
        fix_t        tz;
        logic        emit;
    } carry_t;

    // Folds a binary angle into the first quadrant: {negate, x in Q30}.
    function automatic logic [31:0] sin_reduce(input logic [15:0] a);
        logic [14:0] t;
        t = {1'b0, a[13:0]};
        if (a[14])
        begin
            t = 15'd16384 - t;
        end
        return {a[15], t, 16'd0};
    endfunction

    function automatic logic [30:0] poly_sq(input logic [30:0] x);
        logic [61:0] p;
        p = 62'(x) * 62'(x);
        return p[60:30];
    endfunction

    function automatic logic [29:0] poly_q(input logic [30:0] x2);
        logic [57:0] p;
        p = 58'(SIN_A5) * 58'(x2);
        return SIN_A3 - {3'd0, p[56:30]};
    endfunction

    function automatic logic [30:0] poly_s(input logic [29:0] q, input logic [30:0] x2);
        logic [60:0] p;
        p = 61'(q) * 61'(x2);
        return SIN_A1 - p[60:30];
    endfunction

    function automatic q16_t poly_v(input logic [30:0] s, input logic [30:0] x,
                                    input logic neg);
        logic [61:0] p;
        logic [32:0] y;
        logic [16:0] m;
        p = 62'(s) * 62'(x);
        y = {1'b0, p[61:30]} + 33'd8192;
        m = y[30:14];
        return neg ? q16_t'(-{1'b0, m}) : q16_t'({1'b0, m});
    endfunction
endpackage
`default_nettype wire

FILE: design/cfbq_sin_lane.sv
// Five-stage pipelined binary-angle sine: a quadrant fold, then one polynomial product per stage.
// Depends on cfbq_pkg for the polynomial steps.
`timescale 1ns / 1ps
`default_nettype none
module cfbq_sin_lane (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [15:0]    angle,
    output cfbq_pkg::q16_t      value
);
    import cfbq_pkg::*;

    logic [31:0] red;
    logic [30:0] x0_reg, x1_reg, x2s_reg, x3_reg;
    logic        n0_reg, n1_reg, n2_reg, n3_reg;
    logic [30:0] sq1_reg, sq2_reg;
    logic [29:0] q2_reg;
    logic [30:0] s3_reg;
    q16_t        v4_reg;

    assign red = sin_reduce(angle);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg  <= red[30:0];
            n0_reg  <= red[31];
            sq1_reg <= poly_sq(x0_reg);
            x1_reg  <= x0_reg;
            n1_reg  <= n0_reg;
            q2_reg  <= poly_q(sq1_reg);
            sq2_reg <= sq1_reg;
            x2s_reg <= x1_reg;
            n2_reg  <= n1_reg;
            s3_reg  <= poly_s(q2_reg, sq2_reg);
            x3_reg  <= x2s_reg;
            n3_reg  <= n2_reg;
            v4_reg  <= poly_v(s3_reg, x3_reg, n3_reg);
        end
    end

    assign value = v4_reg;
endmodule
`default_nettype wire

FILE: design/cfbq_front.sv
// Input capture and the four sine lanes for pitch and yaw.
// Depends on cfbq_pkg and cfbq_sin_lane.
`timescale 1ns / 1ps
`default_nettype none
module cfbq_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               accept,
    input  wire logic               allow,
    input  wire logic [30:0]        orbit_distance,
    input  wire logic signed [15:0] pitch_angle,
    input  wire logic signed [15:0] yaw_angle,
    input  wire logic signed [31:0] target_x,
    input  wire logic signed [31:0] target_y,
    input  wire logic signed [31:0] target_z,
    input  wire logic               has_texture,
    output logic                    valid_out,
    output cfbq_pkg::carry_t        carry_out,
    output cfbq_pkg::q16_t          sp,
    output cfbq_pkg::q16_t          cp,
    output cfbq_pkg::q16_t          sy,
    output cfbq_pkg::q16_t          cy
);
    import cfbq_pkg::*;

    logic [15:0] pitch_c, yaw_c;
    logic [4:0]  valid_reg;
    carry_t      carry_reg [5];

    assign pitch_c = pitch_angle + QUARTER_TURN;
    assign yaw_c   = yaw_angle + QUARTER_TURN;

    cfbq_sin_lane u_sp (.clk(clk), .en(en), .angle(pitch_angle), .value(sp));
    cfbq_sin_lane u_cp (.clk(clk), .en(en), .angle(pitch_c),     .value(cp));
    cfbq_sin_lane u_sy (.clk(clk), .en(en), .angle(yaw_angle),   .value(sy));
    cfbq_sin_lane u_cy (.clk(clk), .en(en), .angle(yaw_c),       .value(cy));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg[0] <= '{orbit_d: orbit_distance, tx: target_x, ty: target_y,
                              tz: target_z, emit: allow & has_texture};
            for (int i = 1; i < 5; i++)
            begin
                carry_reg[i] <= carry_reg[i-1];
            end
        end
    end

    assign valid_out = valid_reg[4];
    assign carry_out = carry_reg[4];
endmodule
`default_nettype wire

FILE: design/cfbq_geom.sv
// Four pipeline stages from sines to the saturated corner positions of the quad.
// Depends on cfbq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfbq_geom (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           valid_in,
    input  cfbq_pkg::carry_t    carry_in,
    input  cfbq_pkg::q16_t      sp,
    input  cfbq_pkg::q16_t      cp,
    input  cfbq_pkg::q16_t      sy,
    input  cfbq_pkg::q16_t      cy,
    input  cfbq_pkg::fix_t      half_h,
    input  cfbq_pkg::fix_t      half_w,
    output logic                valid_out,
    output logic                emit_out,
    output cfbq_pkg::quad_t     quad
);
    import cfbq_pkg::*;

    function automatic q16_t mul_qq(input q16_t a, input q16_t b);
        logic [16:0] ma, mb;
        logic [33:0] p;
        logic [17:0] m;
        ma = a[17] ? 17'(-a) : a[16:0];
        mb = b[17] ? 17'(-b) : b[16:0];
        p = 34'(ma) * 34'(mb) + 34'd32768;
        m = p[33:16];
        return (a[17] ^ b[17]) ? q16_t'(-m) : q16_t'(m);
    endfunction

    function automatic logic signed [32:0] mul_dw(input logic [30:0] d, input q16_t w);
        logic [16:0] mw;
        logic [47:0] p;
        mw = w[17] ? 17'(-w) : w[16:0];
        p = 48'(d) * 48'(mw) + 48'd32768;
        return w[17] ? -$signed({1'b0, p[47:16]}) : $signed({1'b0, p[47:16]});
    endfunction

    function automatic logic signed [32:0] mul_vh(input q16_t v, input fix_t h);
        logic [16:0] mv;
        logic [31:0] mh;
        logic [48:0] p;
        mv = v[17] ? 17'(-v) : v[16:0];
        mh = h[31] ? 32'(-h) : 32'(h);
        p = 49'(mv) * 49'(mh) + 49'd32768;
        return (v[17] ^ h[31]) ? -$signed({1'b0, p[47:16]}) : $signed({1'b0, p[47:16]});
    endfunction

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647)
        begin
            return 32'h7FFFFFFF;
        end
        else if (v < -37'sd2147483648)
        begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    logic [3:0] valid_reg;
    logic       emit7_reg, emit8_reg;

    q16_t   w_next [3], r_next [3], u_next [3];
    q16_t   g5_w_reg [3], g5_r_reg [3], g5_u_reg [3];
    carry_t g5_carry_reg, g6_carry_reg;

    logic signed [32:0] g6_o_reg [3], g6_rw_reg [3], g6_uh_reg [3];
    q16_t               g6_w_reg [3];

    logic signed [34:0] g7_c_reg [3];
    logic signed [32:0] g7_rw_reg [3], g7_uh_reg [3];
    logic               emit7_next;

    quad_t quad_next, quad_reg;

    always_comb
    begin
        q16_t um0, um2;
        um0 = mul_qq(sy, sp);
        um2 = mul_qq(cy, sp);
        w_next[0] = mul_qq(cp, sy);
        w_next[1] = sp;
        w_next[2] = mul_qq(cp, cy);
        r_next[1] = '0;
        if (cp != '0)
        begin
            r_next[0] = cp[17] ? -cy : cy;
            r_next[2] = cp[17] ? sy : -sy;
            u_next[0] = cp[17] ? um0 : -um0;
            u_next[1] = cp[17] ? -cp : cp;
            u_next[2] = cp[17] ? um2 : -um2;
        end
        else
        begin
            r_next[0] = 18'sd65536;
            r_next[2] = '0;
            u_next[0] = '0;
            u_next[1] = '0;
            u_next[2] = -sp;
        end
    end

    assign emit7_next = g6_carry_reg.emit &&
                        ((g6_o_reg[0] != '0) || (g6_o_reg[1] != '0) || (g6_o_reg[2] != '0));

    always_comb
    begin
        logic signed [36:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                acc = 37'(g7_c_reg[i])
                    + (j[1] ? 37'(g7_rw_reg[i]) : -37'(g7_rw_reg[i]))
                    + (j[0] ? -37'(g7_uh_reg[i]) : 37'(g7_uh_reg[i]));
                quad_next[i][j] = sat32(acc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g5_carry_reg <= carry_in;
            g6_carry_reg <= g5_carry_reg;
            for (int i = 0; i < 3; i++)
            begin
                g5_w_reg[i]  <= w_next[i];
                g5_r_reg[i]  <= r_next[i];
                g5_u_reg[i]  <= u_next[i];
                g6_o_reg[i]  <= mul_dw(g5_carry_reg.orbit_d, g5_w_reg[i]);
                g6_rw_reg[i] <= mul_vh(g5_r_reg[i], half_w);
                g6_uh_reg[i] <= mul_vh(g5_u_reg[i], half_h);
                g6_w_reg[i]  <= g5_w_reg[i];
                g7_rw_reg[i] <= g6_rw_reg[i];
                g7_uh_reg[i] <= g6_uh_reg[i];
            end
            g7_c_reg[0] <= 35'(g6_carry_reg.tx) + 35'(g6_o_reg[0]) - 35'(g6_w_reg[0]) * 35'sd50;
            g7_c_reg[1] <= 35'(g6_carry_reg.ty) + 35'(g6_o_reg[1]) - 35'(g6_w_reg[1]) * 35'sd50;
            g7_c_reg[2] <= 35'(g6_carry_reg.tz) + 35'(g6_o_reg[2]) - 35'(g6_w_reg[2]) * 35'sd50;
            emit7_reg   <= emit7_next;
            emit8_reg   <= emit7_reg;
            quad_reg    <= quad_next;
        end
    end

    assign valid_out = valid_reg[3];
    assign emit_out  = emit8_reg;
    assign quad      = quad_reg;
endmodule
`default_nettype wire

FILE: design/cfbq_setup.sv
// Configuration registers and the sequencer that derives the quad half sizes.
// Depends on cfbq_pkg; holds a serial restoring divider and sine steps.
`timescale 1ns / 1ps
`default_nettype none
module cfbq_setup (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    output cfbq_pkg::setup_t    st
);
    import cfbq_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HLOAD  = 4'd1;
    localparam logic [3:0] ST_SIN    = 4'd3;
    localparam logic [3:0] ST_X2     = 4'd4;
    localparam logic [3:0] ST_Q      = 4'd5;
    localparam logic [3:0] ST_S      = 4'd6;
    localparam logic [3:0] ST_V      = 4'd7;
    localparam logic [3:0] ST_HHLOAD = 4'd8;
    localparam logic [3:0] ST_HHDIV  = 4'd9;
    localparam logic [3:0] ST_HWLOAD = 4'd10;
    localparam logic [3:0] ST_HWDIV  = 4'd11;

    // Multiplying by this and dropping 32 bits divides a 22-bit value by 90 exactly.
    localparam logic [25:0] H_RECIP = 26'd47721859;

    function automatic fix_t sat_q(input logic [47:0] q, input logic neg);
        if (!neg)
        begin
            return (q > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : fix_t'(q[31:0]);
        end
        return (q >= 48'h80000000) ? 32'sh80000000 : fix_t'(32'd0 - q[31:0]);
    endfunction

    logic        sky_reg, sky_next;
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] fov_reg, fov_next;
    logic [13:0] ww_reg, ww_next, wh_reg, wh_next;
    logic [3:0]  state_reg, state_next;
    logic        phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [15:0] ang_reg, ang_next;
    logic [30:0] x_reg, x_next, x2_reg, x2_next, s_reg, s_next;
    logic        neg_reg, neg_next;
    logic [29:0] q_reg, q_next;
    q16_t        sh_reg, sh_next, ch_reg, ch_next;
    fix_t        hh_reg, hh_next, hw_reg, hw_next;
    logic [17:0] rem_reg, rem_next, den_reg, den_next;
    logic [47:0] quo_reg, quo_next;

    logic [18:0] trial;
    logic        ge;
    logic [17:0] rem_step;
    logic [47:0] quo_step;
    logic [31:0] red;
    logic [16:0] msh, mch;
    logic [31:0] mhh;
    q16_t        v_new;
    logic [21:0] h_num;
    logic [47:0] h_prod;

    assign trial    = {rem_reg, quo_reg[47]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_step = ge ? 18'(trial - {1'b0, den_reg}) : trial[17:0];
    assign quo_step = {quo_reg[46:0], ge};
    assign red      = sin_reduce(phase_reg ? ang_reg + QUARTER_TURN : ang_reg);
    assign msh      = sh_reg[17] ? 17'(-sh_reg) : sh_reg[16:0];
    assign mch      = ch_reg[17] ? 17'(-ch_reg) : ch_reg[16:0];
    assign mhh      = hh_reg[31] ? 32'(-hh_reg) : 32'(hh_reg);
    assign v_new    = poly_v(s_reg, x_reg, neg_reg);
    assign h_num    = {1'b0, fov_reg, 5'd0} + 22'd45;
    assign h_prod   = 48'(h_num) * 48'(H_RECIP);

    always_comb
    begin
        sky_next   = sky_reg;
        mode_next  = mode_reg;
        fov_next   = fov_reg;
        ww_next    = ww_reg;
        wh_next    = wh_reg;
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        ang_next   = ang_reg;
        x_next     = x_reg;
        neg_next   = neg_reg;
        x2_next    = x2_reg;
        q_next     = q_reg;
        s_next     = s_reg;
        sh_next    = sh_reg;
        ch_next    = ch_reg;
        hh_next    = hh_reg;
        hw_next    = hw_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_HLOAD:
            begin
                ang_next   = h_prod[47:32];
                phase_next = 1'b0;
                state_next = ST_SIN;
            end
            ST_HHDIV, ST_HWDIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == ST_HHDIV)
                    begin
                        hh_next    = sat_q(quo_step, sh_reg[17] ^ ch_reg[17]);
                        state_next = ST_HWLOAD;
                    end
                    else
                    begin
                        hw_next    = sat_q(quo_step, hh_reg[31]);
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SIN:
            begin
                x_next     = red[30:0];
                neg_next   = red[31];
                state_next = ST_X2;
            end
            ST_X2:
            begin
                x2_next    = poly_sq(x_reg);
                state_next = ST_Q;
            end
            ST_Q:
            begin
                q_next     = poly_q(x2_reg);
                state_next = ST_S;
            end
            ST_S:
            begin
                s_next     = poly_s(q_reg, x2_reg);
                state_next = ST_V;
            end
            ST_V:
            begin
                if (!phase_reg)
                begin
                    sh_next    = v_new;
                    phase_next = 1'b1;
                    state_next = ST_SIN;
                end
                else
                begin
                    ch_next    = v_new;
                    state_next = ST_HHLOAD;
                end
            end
            ST_HHLOAD:
            begin
                if (ch_reg == '0)
                begin
                    hh_next    = 32'sh7FFFFFFF;
                    state_next = ST_HWLOAD;
                end
                else
                begin
                    quo_next   = ((48'(msh) * 48'd100) << 16) + 48'(mch);
                    den_next   = {mch, 1'b0};
                    rem_next   = '0;
                    cnt_next   = 6'd47;
                    state_next = ST_HHDIV;
                end
            end
            ST_HWLOAD:
            begin
                quo_next   = ((48'(mhh) * 48'(ww_reg)) << 1) + 48'(wh_reg);
                den_next   = {3'd0, wh_reg, 1'b0};
                rem_next   = '0;
                cnt_next   = 6'd47;
                state_next = ST_HWDIV;
            end
            default:
            begin
                state_next = ST_HLOAD;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SKY_ENABLE:    sky_next  = cfg_data[0];
                CFG_RENDER_MODE:   mode_next = cfg_data[1:0];
                CFG_FOV_Q8:        fov_next  = cfg_data;
                CFG_WINDOW_WIDTH:  ww_next   = cfg_data[13:0];
                CFG_WINDOW_HEIGHT: wh_next   = cfg_data[13:0];
                default:           sky_next  = sky_reg;
            endcase
            state_next = ST_HLOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sky_reg   <= 1'b1;
            mode_reg  <= 2'd0;
            fov_reg   <= 16'd15360;
            ww_reg    <= 14'd1920;
            wh_reg    <= 14'd1080;
            state_reg <= ST_HLOAD;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            sky_reg   <= sky_next;
            mode_reg  <= mode_next;
            fov_reg   <= fov_next;
            ww_reg    <= ww_next;
            wh_reg    <= wh_next;
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
        x_reg   <= x_next;
        neg_reg <= neg_next;
        x2_reg  <= x2_next;
        q_reg   <= q_next;
        s_reg   <= s_next;
        sh_reg  <= sh_next;
        ch_reg  <= ch_next;
        hh_reg  <= hh_next;
        hw_reg  <= hw_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign st.busy   = state_reg != ST_IDLE;
    assign st.allow  = sky_reg && (mode_reg != MODE_MESH_ONLY) && (ww_reg != '0) && (wh_reg != '0);
    assign st.half_h = hh_reg;
    assign st.half_w = hw_reg;
endmodule
`default_nettype wire

FILE: design/cfbq_emit.sv
// Vertex emitter: holds one quad and hands out its six vertices in order.
// Depends on cfbq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "camera_facing_backdrop_quad_top_defines.svh"
module cfbq_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           ld_valid,
    input  cfbq_pkg::quad_t     quad,
    input  wire logic           out_ready,
    output logic                take,
    output logic                out_valid,
    output logic signed [31:0]  vert_x,
    output logic signed [31:0]  vert_y,
    output logic signed [31:0]  vert_z,
    output logic                tex_u,
    output logic                tex_v,
    output logic                last_vertex
);
    import cfbq_pkg::*;

    localparam logic [2:0] K_LAST = 3'd5;

    // Corner order is TL, BL, TR, TR, BL, BR; the result is {u, v}.
    function automatic logic [1:0] corner_uv(input logic [2:0] k);
        unique case (k)
            3'd0:    return 2'b00;
            3'd1:    return 2'b01;
            3'd2:    return 2'b10;
            3'd3:    return 2'b10;
            3'd4:    return 2'b01;
            3'd5:    return 2'b11;
            default: return 2'b00;
        endcase
    endfunction

    logic        busy_reg, busy_next;
    logic [2:0]  k_reg, k_next;
    quad_t       quad_reg;
    logic        load;
    logic [1:0]  uv;

    assign take = !busy_reg || ((k_reg == K_LAST) && out_ready);
    assign load = ld_valid && take;

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (load)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (k_reg == K_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg <= quad;
        end
    end

    assign uv          = corner_uv(k_reg);
    assign out_valid   = busy_reg;
    assign vert_x      = $signed(quad_reg[0][uv]);
    assign vert_y      = $signed(quad_reg[1][uv]);
    assign vert_z      = $signed(quad_reg[2][uv]);
    assign tex_u       = uv[1];
    assign tex_v       = uv[0];
    assign last_vertex = k_reg == K_LAST;

    `CFBQ_ASSERT_IMP(a_k_range, busy_reg, k_reg <= K_LAST)
    `CFBQ_ASSERT_NXT(a_k_step, busy_reg && out_ready && (k_reg != K_LAST), busy_reg && (k_reg == $past(k_reg) + 3'd1))
    `CFBQ_ASSERT_NXT(a_drain, busy_reg && out_ready && (k_reg == K_LAST) && !ld_valid, !busy_reg)
endmodule
`default_nettype wire

FILE: design/camera_facing_backdrop_quad_top.sv
// Vertices come out one per cycle while out_ready is high; the six-vertex emitter loads the
// next camera transaction's quad as the last vertex of the current one is taken.
// Suppressed inputs produce no vertices and pass through the 9-stage pipeline only.
// Reset and every configuration write start the half-size sequencer (two sines, then two
// 48-step divisions, the first skipped at zero half-angle cosine); in_ready is low meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module camera_facing_backdrop_quad_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [30:0]        orbit_distance,
    input  wire logic signed [15:0] pitch_angle,
    input  wire logic signed [15:0] yaw_angle,
    input  wire logic signed [31:0] target_x,
    input  wire logic signed [31:0] target_y,
    input  wire logic signed [31:0] target_z,
    input  wire logic               has_texture,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      vert_x,
    output logic signed [31:0]      vert_y,
    output logic signed [31:0]      vert_z,
    output logic                    tex_u,
    output logic                    tex_v,
    output logic                    last_vertex
);
    import cfbq_pkg::*;

    setup_t st;
    carry_t carry;
    q16_t   sp, cp, sy, cy;
    quad_t  quad;
    logic   en, accept, front_valid, geom_valid, geom_emit, take;

    assign en       = !(geom_valid && geom_emit && !take);
    assign in_ready = en && !st.busy;
    assign accept   = in_valid && in_ready;

    cfbq_setup u_setup (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .st(st)
    );

    cfbq_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .accept(accept), .allow(st.allow),
        .orbit_distance(orbit_distance), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .target_x(target_x), .target_y(target_y),
        .target_z(target_z), .has_texture(has_texture),
        .valid_out(front_valid), .carry_out(carry),
        .sp(sp), .cp(cp), .sy(sy), .cy(cy)
    );

    cfbq_geom u_geom (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(front_valid), .carry_in(carry),
        .sp(sp), .cp(cp), .sy(sy), .cy(cy), .half_h(st.half_h), .half_w(st.half_w),
        .valid_out(geom_valid), .emit_out(geom_emit), .quad(quad)
    );

    cfbq_emit u_emit (
        .clk(clk), .rst_n(rst_n), .ld_valid(geom_valid && geom_emit), .quad(quad),
        .out_ready(out_ready), .take(take), .out_valid(out_valid),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
        .tex_u(tex_u), .tex_v(tex_v), .last_vertex(last_vertex)
    );
endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for camera_facing_backdrop_quad_top: random and directed camera
// transactions are checked against a bit-exact predictor of the six quad vertices.
// Depends on cfbq_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
    import cfbq_pkg::*;

    localparam logic [1:0] MODE_BACKDROP = 2'd0;
    localparam logic [1:0] MODE_HYBRID   = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam bit [0:5] CORNER_U = 6'b001101;
    localparam bit [0:5] CORNER_V = 6'b010011;
    localparam longint INT32_HI = 64'sd2147483647;
    localparam longint INT32_LO = -64'sd2147483648;

    typedef struct {
        logic [30:0]        orbit_d;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic               tex;
    } camera_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               u;
        logic               v;
        logic               last;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [30:0] orbit_distance = '0;
    logic signed [15:0] pitch_angle = '0;
    logic signed [15:0] yaw_angle = '0;
    logic signed [31:0] target_x = '0;
    logic signed [31:0] target_y = '0;
    logic signed [31:0] target_z = '0;
    logic has_texture = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic tex_u;
    logic tex_v;
    logic last_vertex;

    camera_t cam_pending[$];
    vertex_t vertex_expected[$];
    int fail_count = 0;
    int cams_accepted = 0;
    bit cam_taken = 1'b0;
    bit no_gaps = 1'b0;
    int cam_gap = 0;
    int rx_stall = 0;
    int hold_left = 0;
    bit held = 1'b0;

    logic       m_sky_enable = 1'b1;
    logic [1:0] m_render_mode = MODE_BACKDROP;
    logic [15:0] m_fov = 16'd15360;
    logic [13:0] m_width = 14'd1920;
    logic [13:0] m_height = 14'd1080;

    camera_facing_backdrop_quad_top dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint ang_sin(input logic [15:0] a);
        longint unsigned t, x, x2, q, s, y;
        longint v;
        t = a[13:0];
        if (a[14])
        begin
            t = 16384 - t;
        end
        x = t << 16;
        x2 = (x * x) >> 30;
        q = 64'(SIN_A3) - ((64'(SIN_A5) * x2) >> 30);
        s = 64'(SIN_A1) - ((q * x2) >> 30);
        y = (s * x) >> 30;
        v = longint'((y + 8192) >> 14);
        return a[15] ? -v : v;
    endfunction

    function automatic longint round_mul(input longint a, input longint b, input int sh);
        longint unsigned p;
        p = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
        p = (p + (64'd1 << (sh - 1))) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > INT32_HI)
        begin
            return INT32_HI;
        end
        if (v < INT32_LO)
        begin
            return INT32_LO;
        end
        return v;
    endfunction

    task automatic predict_quad(input camera_t c);
        longint d, sp, cp, sy, cy, sg, sh, ch, hh, hw, v;
        longint w[3], o[3], tg[3], ctr[3], r[3], up[3], rw[3], uh[3];
        longint unsigned num, den, q;
        logic [15:0] h;
        vertex_t vx;
        if (!m_sky_enable || m_render_mode == MODE_MESH_ONLY || !c.tex
            || m_width == 0 || m_height == 0)
        begin
            return;
        end
        d = c.orbit_d;
        tg[0] = c.tx;
        tg[1] = c.ty;
        tg[2] = c.tz;
        sp = ang_sin(c.pitch);
        cp = ang_sin(c.pitch + QUARTER_TURN);
        sy = ang_sin(c.yaw);
        cy = ang_sin(c.yaw + QUARTER_TURN);
        w[0] = round_mul(cp, sy, 16);
        w[1] = sp;
        w[2] = round_mul(cp, cy, 16);
        for (int i = 0; i < 3; i++)
        begin
            o[i] = round_mul(d, w[i], 16);
        end
        if (o[0] == 0 && o[1] == 0 && o[2] == 0)
        begin
            return;
        end
        if (cp != 0)
        begin
            sg = cp > 0 ? 1 : -1;
            r = '{sg * cy, 0, -sg * sy};
            up = '{-sg * round_mul(sy, sp, 16), cp > 0 ? cp : -cp,
                   -sg * round_mul(cy, sp, 16)};
        end
        else
        begin
            r = '{65536, 0, 0};
            up = '{0, 0, -sp};
        end
        for (int i = 0; i < 3; i++)
        begin
            ctr[i] = tg[i] + o[i] - 50 * w[i];
        end
        h = 16'((32'(m_fov) * 32 + 45) / 90);
        sh = ang_sin(h);
        ch = ang_sin(h + QUARTER_TURN);
        if (ch == 0)
        begin
            hh = INT32_HI;
        end
        else
        begin
            num = 64'd50 * longint'(sh < 0 ? -sh : sh) * 64'd65536;
            den = ch < 0 ? -ch : ch;
            q = (2 * num + den) / (2 * den);
            hh = clamp32(((sh < 0) != (ch < 0)) ? -longint'(q) : longint'(q));
        end
        num = longint'(hh < 0 ? -hh : hh) * longint'(m_width);
        q = (2 * num + m_height) / (2 * longint'(m_height));
        hw = clamp32(hh < 0 ? -longint'(q) : longint'(q));
        for (int i = 0; i < 3; i++)
        begin
            rw[i] = round_mul(r[i], hw, 16);
            uh[i] = round_mul(up[i], hh, 16);
        end
        for (int k = 0; k < 6; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v = ctr[i] + (CORNER_U[k] ? rw[i] : -rw[i]) + (CORNER_V[k] ? -uh[i] : uh[i]);
                v = clamp32(v);
                if (i == 0) vx.x = 32'(v);
                else if (i == 1) vx.y = 32'(v);
                else vx.z = 32'(v);
            end
            vx.u = CORNER_U[k];
            vx.v = CORNER_V[k];
            vx.last = (k == 5);
            vertex_expected = {vertex_expected, vx};
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cam_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            predict_quad('{orbit_distance, pitch_angle, yaw_angle, target_x, target_y,
                           target_z, has_texture});
            cams_accepted <= cams_accepted + 1;
        end
    end

    always @(negedge clk)
    begin : cam_driver
        camera_t c;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !cam_taken)
        begin
        end
        else if (cam_gap > 0)
        begin
            in_valid <= 1'b0;
            cam_gap <= cam_gap - 1;
        end
        else if (cam_pending.size() > 0)
        begin
            c = cam_pending.pop_front();
            in_valid <= 1'b1;
            orbit_distance <= c.orbit_d;
            pitch_angle <= c.pitch;
            yaw_angle <= c.yaw;
            target_x <= c.tx;
            target_y <= c.ty;
            target_z <= c.tz;
            has_texture <= c.tex;
            cam_gap <= pick_gap();
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!held && cams_accepted >= 50)
        begin
            held = 1'b1;
            out_ready <= 1'b0;
            hold_left <= 400;
        end
        else if (rx_stall > 0)
        begin
            out_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            rx_stall <= pick_gap();
        end
    end

    always @(posedge clk)
    begin : vertex_monitor
        vertex_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (vertex_expected.size() == 0)
            begin
                $error("Vertex transaction arrived with none expected.");
                fail_count++;
            end
            else
            begin
                e = vertex_expected.pop_front();
                if (vert_x !== e.x)
                begin
                    $error("vert_x expected %0d actual %0d", e.x, vert_x);
                    fail_count++;
                end
                if (vert_y !== e.y)
                begin
                    $error("vert_y expected %0d actual %0d", e.y, vert_y);
                    fail_count++;
                end
                if (vert_z !== e.z)
                begin
                    $error("vert_z expected %0d actual %0d", e.z, vert_z);
                    fail_count++;
                end
                if (tex_u !== e.u)
                begin
                    $error("tex_u expected %0d actual %0d", e.u, tex_u);
                    fail_count++;
                end
                if (tex_v !== e.v)
                begin
                    $error("tex_v expected %0d actual %0d", e.v, tex_v);
                    fail_count++;
                end
                if (last_vertex !== e.last)
                begin
                    $error("last_vertex expected %0d actual %0d", e.last, last_vertex);
                    fail_count++;
                end
            end
        end
    end

    task automatic add_cam(input logic [30:0] d, input logic [15:0] p, input logic [15:0] y,
                           input logic [31:0] x, input logic [31:0] yy, input logic [31:0] z,
                           input logic tex);
        camera_t c;
        c = '{d, p, y, x, yy, z, tex};
        cam_pending = {cam_pending, c};
    endtask

    task automatic add_random_cams(input int n);
        logic [30:0] d;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            d = (r < 4) ? 31'($urandom_range(0, 4095)) << $urandom_range(0, 16) : 31'($urandom);
            add_cam(d, 16'($urandom), 16'($urandom),
                    (r == 9) ? 32'h7FFF_FFFF : 32'($urandom), 32'($urandom),
                    (r == 8) ? 32'h8000_0000 : 32'($urandom), $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SKY_ENABLE: m_sky_enable = val[0];
            CFG_RENDER_MODE: m_render_mode = val[1:0];
            CFG_FOV_Q8: m_fov = val;
            CFG_WINDOW_WIDTH: m_width = val[13:0];
            CFG_WINDOW_HEIGHT: m_height = val[13:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic sky, input logic [1:0] mode, input logic [15:0] fov,
                              input logic [13:0] wd, input logic [13:0] ht);
        write_reg(CFG_SKY_ENABLE, 16'(sky));
        write_reg(CFG_RENDER_MODE, 16'(mode));
        write_reg(CFG_FOV_Q8, fov);
        write_reg(CFG_WINDOW_WIDTH, 16'(wd));
        write_reg(CFG_WINDOW_HEIGHT, 16'(ht));
    endtask

    task automatic wait_drained();
        while (cam_pending.size() != 0 || in_valid || vertex_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        add_cam(31'h0001_0000, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_cam(31'h7FFF_FFFF, 16'd0, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        add_cam(31'h7FFF_FFFF, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 1'b1);
        add_cam(31'h000A_0000, 16'd16384, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_cam(31'h000A_0000, 16'hC000, 16'd4096, 32'd100, 32'd0, 32'd0, 1'b1);
        add_cam(31'h000A_0000, 16'h7FFF, 16'h7FFF, 32'd0, 32'd0, 32'd0, 1'b1);
        add_cam(31'h000A_0000, 16'd20000, 16'hFFFF, 32'd0, 32'd0, 32'd0, 1'b1);
        add_cam(31'd0, 16'd1000, 16'd2000, 32'd0, 32'd0, 32'd0, 1'b1);
        add_cam(31'd1, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_cam(31'h000A_0000, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_cam(31'h0100_0000, 16'd8192, 16'd8192, 32'hFFFF_0000, 32'h0001_0000,
                32'd5, 1'b1);
        add_cam(31'h0000_8000, 16'hE000, 16'hA000, 32'd7, 32'hFFFF_FFFF, 32'd0, 1'b1);
        wait_drained();
        no_gaps = 1'b1;
        add_random_cams(25);
        wait_drained();
        no_gaps = 1'b0;
        add_random_cams(60);
        wait_drained();

        set_config(1'b1, MODE_HYBRID, 16'd256, 14'd1, 14'd8192);
        add_random_cams(30);
        wait_drained();
        set_config(1'b1, MODE_UNUSED, 16'd45824, 14'd16383, 14'd1);
        add_random_cams(30);
        wait_drained();
        set_config(1'b1, MODE_BACKDROP, 16'd46080, 14'd640, 14'd480);
        add_random_cams(25);
        wait_drained();
        set_config(1'b1, MODE_HYBRID, 16'hFFFF, 14'd800, 14'd600);
        add_random_cams(25);
        wait_drained();
        set_config(1'b1, MODE_MESH_ONLY, 16'd15360, 14'd1920, 14'd1080);
        add_random_cams(10);
        wait_drained();
        set_config(1'b0, MODE_BACKDROP, 16'd15360, 14'd1920, 14'd1080);
        add_random_cams(10);
        wait_drained();
        set_config(1'b1, MODE_BACKDROP, 16'd15360, 14'd0, 14'd1080);
        add_random_cams(5);
        wait_drained();
        set_config(1'b1, MODE_BACKDROP, 16'd15360, 14'd1080, 14'd0);
        add_random_cams(5);
        wait_drained();
        set_config(1'b1, MODE_BACKDROP, 16'($urandom_range(256, 45824)),
                   14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
        add_random_cams(40);
        wait_drained();

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
